[src/lfu_cache_lru_tiebreak_assert.svh]
// Assertion macros shared by the cache RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

[src/lfc_pkg.sv]
// Package for the LFU cache: sizes, action codes and the update command.
// No dependencies; used by lfc_store and lfu_cache_lru_tiebreak.
package lfc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W  = 5;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 32;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  // One write command from the sequencer to the entry store.
  typedef struct packed {
    logic              en;
    logic              bump;
    logic              wr_data;
    logic              ins;
    logic              evict;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W-1:0]  evict_slot;
    logic [RANK_W-1:0] ref_rank;
    logic [CNT_W-1:0]  count;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } upd_cmd_t;

endpackage

[src/lfc_store.sv]
// Entry store of the LFU cache: keys, data, use counts, recency ranks, valid bits.
// Depends on lfc_pkg; one read index per cycle, one update command per item.
module lfc_store
  import lfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic              rd_valid,
  output logic [KEY_W-1:0]  rd_key,
  output logic [DATA_W-1:0] rd_data,
  output logic [CNT_W-1:0]  rd_cnt,
  output logic [RANK_W-1:0] rd_rank,
  output logic [MAX_ENTRIES-1:0] valid_vec,
  input  upd_cmd_t          cmd
);

  logic [MAX_ENTRIES-1:0] valid_r;
  logic [MAX_ENTRIES-1:0] valid_nxt;
  logic [KEY_W-1:0]  key_r   [MAX_ENTRIES];
  logic [DATA_W-1:0] data_r  [MAX_ENTRIES];
  logic [CNT_W-1:0]  cnt_r   [MAX_ENTRIES];
  logic [RANK_W-1:0] rank_r  [MAX_ENTRIES];
  logic [RANK_W-1:0] rank_nxt[MAX_ENTRIES];

  assign rd_valid  = valid_r[rd_idx];
  assign rd_key    = key_r[rd_idx];
  assign rd_data   = data_r[rd_idx];
  assign rd_cnt    = cnt_r[rd_idx];
  assign rd_rank   = rank_r[rd_idx];
  assign valid_vec = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.en && cmd.evict) begin
      valid_nxt[cmd.evict_slot] = 1'b0;
    end
    if (cmd.en && cmd.ins) begin
      valid_nxt[cmd.slot] = 1'b1;
    end
  end

  // Each rank moves on its own: a bump ages the entries that were more recent
  // than the bumped one, an insert ages all survivors after closing the gap
  // left by the victim.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (cmd.en && cmd.bump) begin
        if (IDX_W'(i) == cmd.slot) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && rank_r[i] < cmd.ref_rank) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end else if (cmd.en && cmd.ins) begin
        if (IDX_W'(i) == cmd.slot) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && !(cmd.evict && IDX_W'(i) == cmd.evict_slot)) begin
          if (cmd.evict && rank_r[i] > cmd.ref_rank) begin
            rank_nxt[i] = rank_r[i];
          end else begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_r[i] <= rank_nxt[i];
    end
    if (cmd.en && (cmd.bump || cmd.ins)) begin
      cnt_r[cmd.slot] <= cmd.count;
    end
    if (cmd.en && cmd.wr_data) begin
      data_r[cmd.slot] <= cmd.data;
    end
    if (cmd.en && cmd.ins) begin
      key_r[cmd.slot] <= cmd.key;
    end
  end

endmodule

[src/lfu_cache_lru_tiebreak.sv]
// LFU cache with LRU tie-break: a fully associative key-value store of
// MAX_ENTRIES entries (16) with least-frequently-used replacement.
//
// Channels: the in_ channel carries one item (action get/put, key, value);
// the out_ channel returns one result per item (hit, read_value, evicted,
// evicted_key). Both use valid/ready. The cfg_ channel writes the capacity
// register; users do so only while the block is idle (unchecked). cfg_ready
// is always high.
// Flow: an accepted item scans the store one entry per cycle through a
// single key/count compare unit, then commits its update in the update
// state once the output register is free. out_valid is registered and rises
// as the block returns to idle, so a new item can be taken while the result
// waits; it is not taken before the last item has committed.
//
// Reset: all entries become invalid, the fill level is zero and capacity is
// 16. There is no clearing pass; the block is ready right after reset.
// Stall: a finished result waits in the output register; a following item
// may be taken and scanned meanwhile, and it holds in its update cycle until
// the output register is free.
`include "lfu_cache_lru_tiebreak_assert.svh"

module lfu_cache_lru_tiebreak
  import lfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [DATA_W-1:0] out_read_value,
  output logic              out_evicted,
  output logic [KEY_W-1:0]  out_evicted_key,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_capacity
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD} state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              act_r, act_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  logic              m_found_r, m_found_nxt;
  logic [IDX_W-1:0]  m_slot_r, m_slot_nxt;
  logic [DATA_W-1:0] m_data_r, m_data_nxt;
  logic [CNT_W-1:0]  m_cnt_r, m_cnt_nxt;
  logic [RANK_W-1:0] m_rank_r, m_rank_nxt;

  logic              v_found_r, v_found_nxt;
  logic [IDX_W-1:0]  v_slot_r, v_slot_nxt;
  logic [KEY_W-1:0]  v_key_r, v_key_nxt;
  logic [CNT_W-1:0]  v_cnt_r, v_cnt_nxt;
  logic [RANK_W-1:0] v_rank_r, v_rank_nxt;

  logic              f_found_r, f_found_nxt;
  logic [IDX_W-1:0]  f_slot_r, f_slot_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [DATA_W-1:0] out_rv_r, out_rv_nxt;
  logic              out_ev_r, out_ev_nxt;
  logic [KEY_W-1:0]  out_ek_r, out_ek_nxt;

  logic              rd_valid;
  logic [KEY_W-1:0]  rd_key;
  logic [DATA_W-1:0] rd_data;
  logic [CNT_W-1:0]  rd_cnt;
  logic [RANK_W-1:0] rd_rank;
  logic [MAX_ENTRIES-1:0] entry_valid;

  logic              is_match;
  logic              is_better;
  logic [FILL_W-1:0] cap_eff;
  logic [CNT_W-1:0]  cnt_inc;
  logic              commit;
  logic              do_evict;
  logic              do_ins;
  upd_cmd_t          cmd;

  lfc_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (idx_r),
    .rd_valid  (rd_valid),
    .rd_key    (rd_key),
    .rd_data   (rd_data),
    .rd_cnt    (rd_cnt),
    .rd_rank   (rd_rank),
    .valid_vec (entry_valid),
    .cmd       (cmd)
  );

  assign in_ready        = (state_r == ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rv_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_ek_r;

  assign cap_eff = (32'(cap_r) > MAX_ENTRIES) ? FILL_W'(MAX_ENTRIES) : FILL_W'(cap_r);
  assign cnt_inc = (&m_cnt_r) ? m_cnt_r : m_cnt_r + 1'b1;
  assign commit  = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  // Shared compare unit: key match and victim order for the entry under scan.
  assign is_match  = rd_valid && (rd_key == key_r) && !m_found_r;
  assign is_better = rd_valid && (!v_found_r || rd_cnt < v_cnt_r ||
                     (rd_cnt == v_cnt_r && rd_rank > v_rank_r));

  always_comb begin
    do_evict = 1'b0;
    do_ins   = 1'b0;
    cmd      = '0;
    cmd.en   = commit;
    cmd.key  = key_r;
    cmd.data = val_r;
    if (act_r == ACT_GET) begin
      if (m_found_r) begin
        cmd.bump     = 1'b1;
        cmd.slot     = m_slot_r;
        cmd.ref_rank = m_rank_r;
        cmd.count    = cnt_inc;
      end
    end else if (cap_eff != '0) begin
      if (m_found_r) begin
        cmd.bump     = 1'b1;
        cmd.wr_data  = 1'b1;
        cmd.slot     = m_slot_r;
        cmd.ref_rank = m_rank_r;
        cmd.count    = cnt_inc;
      end else begin
        do_evict = (fill_r >= cap_eff) && v_found_r;
        do_ins   = do_evict || f_found_r;
        cmd.evict      = do_evict;
        cmd.evict_slot = v_slot_r;
        cmd.ref_rank   = v_rank_r;
        cmd.ins        = do_ins;
        cmd.wr_data    = do_ins;
        cmd.count      = CNT_W'(1);
        // The lowest free slot takes the new entry, the victim's included.
        if (do_evict && !(f_found_r && f_slot_r < v_slot_r)) begin
          cmd.slot = v_slot_r;
        end else begin
          cmd.slot = f_slot_r;
        end
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cap_nxt     = cap_r;
    fill_nxt    = fill_r;
    act_nxt     = act_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    m_found_nxt = m_found_r;
    m_slot_nxt  = m_slot_r;
    m_data_nxt  = m_data_r;
    m_cnt_nxt   = m_cnt_r;
    m_rank_nxt  = m_rank_r;
    v_found_nxt = v_found_r;
    v_slot_nxt  = v_slot_r;
    v_key_nxt   = v_key_r;
    v_cnt_nxt   = v_cnt_r;
    v_rank_nxt  = v_rank_r;
    f_found_nxt = f_found_r;
    f_slot_nxt  = f_slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    out_rv_nxt    = out_rv_r;
    out_ev_nxt    = out_ev_r;
    out_ek_nxt    = out_ek_r;

    if (cfg_valid) begin
      cap_nxt = cfg_capacity;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt     = in_action;
          key_nxt     = in_key;
          val_nxt     = in_value;
          idx_nxt     = '0;
          m_found_nxt = 1'b0;
          v_found_nxt = 1'b0;
          f_found_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (is_match) begin
          m_found_nxt = 1'b1;
          m_slot_nxt  = idx_r;
          m_data_nxt  = rd_data;
          m_cnt_nxt   = rd_cnt;
          m_rank_nxt  = rd_rank;
        end
        if (is_better) begin
          v_found_nxt = 1'b1;
          v_slot_nxt  = idx_r;
          v_key_nxt   = rd_key;
          v_cnt_nxt   = rd_cnt;
          v_rank_nxt  = rd_rank;
        end
        if (!rd_valid && !f_found_r) begin
          f_found_nxt = 1'b1;
          f_slot_nxt  = idx_r;
        end
        if (idx_r == IDX_W'(MAX_ENTRIES - 1)) begin
          state_nxt = ST_UPD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_UPD: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = m_found_r;
          out_rv_nxt    = (act_r == ACT_GET && m_found_r) ? m_data_r : '0;
          out_ev_nxt    = do_evict;
          out_ek_nxt    = do_evict ? v_key_r : '0;
          fill_nxt      = fill_r - FILL_W'(do_evict) + FILL_W'(do_ins);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_W'(16);
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      m_found_r   <= 1'b0;
      v_found_r   <= 1'b0;
      f_found_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      m_found_r   <= m_found_nxt;
      v_found_r   <= v_found_nxt;
      f_found_r   <= f_found_nxt;
    end
    act_r    <= act_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    m_slot_r <= m_slot_nxt;
    m_data_r <= m_data_nxt;
    m_cnt_r  <= m_cnt_nxt;
    m_rank_r <= m_rank_nxt;
    v_slot_r <= v_slot_nxt;
    v_key_r  <= v_key_nxt;
    v_cnt_r  <= v_cnt_nxt;
    v_rank_r <= v_rank_nxt;
    f_slot_r <= f_slot_nxt;
    out_hit_r <= out_hit_nxt;
    out_rv_r  <= out_rv_nxt;
    out_ev_r  <= out_ev_nxt;
    out_ek_r  <= out_ek_nxt;
  end

  `LFC_ASSERT_IMP(a_fill_matches_valid, clk, rst_n, 1'b1,
                  $countones(entry_valid) == 32'(fill_r))
  `LFC_ASSERT_IMP(a_victim_is_valid, clk, rst_n, commit && cmd.evict,
                  entry_valid[cmd.evict_slot])
  `LFC_ASSERT_IMP(a_insert_into_free, clk, rst_n, commit && cmd.ins && !cmd.evict,
                  !entry_valid[cmd.slot])
  `LFC_ASSERT_NXT(a_insert_marks_valid, clk, rst_n, commit && cmd.ins,
                  entry_valid[$past(cmd.slot)])
  `LFC_ASSERT_IMP(a_evict_only_on_miss, clk, rst_n, out_valid_r && out_ev_r,
                  !out_hit_r)

endmodule

[verif/testbench.sv]
// Self-checking testbench for lfu_cache_lru_tiebreak: directed and random get/put items.
// Depends on lfc_pkg and the cache RTL; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module testbench;
  import lfc_pkg::*;

  localparam int POOL_MAX = 24;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } cache_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_action = ACT_GET;
  logic [KEY_W-1:0]  in_key = '0;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  logic              out_hit;
  logic [DATA_W-1:0] out_read_value;
  logic              out_evicted;
  logic [KEY_W-1:0]  out_evicted_key;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_capacity = '0;

  // Predictor copy of the store.
  logic              slot_valid [MAX_ENTRIES];
  logic [KEY_W-1:0]  slot_key   [MAX_ENTRIES];
  logic [DATA_W-1:0] slot_data  [MAX_ENTRIES];
  logic [CNT_W-1:0]  slot_uses  [MAX_ENTRIES];
  int                slot_age   [MAX_ENTRIES];
  int                occupancy;
  logic [CAP_W-1:0]  cap_reg;

  cache_result_t     pending_results [$];
  logic [KEY_W-1:0]  key_pool [POOL_MAX];
  int                mismatch_count = 0;
  bit                idle_on = 1'b0;

  lfu_cache_lru_tiebreak dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 50) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Bump an entry: count up (saturating) and make it the most recent.
  task automatic touch_slot(input int s);
    int i;
    int age;
    age = slot_age[s];
    if (slot_uses[s] != '1) begin
      slot_uses[s]++;
    end
    for (i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_valid[i] && i != s && slot_age[i] < age) begin
        slot_age[i]++;
      end
    end
    slot_age[s] = 0;
  endtask

  task automatic cache_predict(input logic act, input logic [KEY_W-1:0] k,
                               input logic [DATA_W-1:0] v, output cache_result_t r);
    int i;
    int s;
    int victim;
    int free_slot;
    int lim;
    int age;
    s = -1;
    for (i = 0; i < MAX_ENTRIES; i++) begin
      if (s < 0 && slot_valid[i] && slot_key[i] == k) begin
        s = i;
      end
    end
    r = '0;
    r.hit = (s >= 0);
    lim = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg);
    if (act == ACT_GET) begin
      if (s >= 0) begin
        r.read_value = slot_data[s];
        touch_slot(s);
      end
    end else if (lim == 0) begin
      // Puts are dropped entirely when storing is disabled.
    end else if (s >= 0) begin
      slot_data[s] = v;
      touch_slot(s);
    end else begin
      if (occupancy >= lim) begin
        victim = -1;
        for (i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
              (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))) begin
            victim = i;
          end
        end
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[victim];
          age = slot_age[victim];
          slot_valid[victim] = 1'b0;
          for (i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_valid[i] && slot_age[i] > age) begin
              slot_age[i]--;
            end
          end
          occupancy--;
        end
      end
      free_slot = -1;
      for (i = 0; i < MAX_ENTRIES; i++) begin
        if (free_slot < 0 && !slot_valid[i]) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        for (i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_valid[i]) begin
            slot_age[i]++;
          end
        end
        slot_valid[free_slot] = 1'b1;
        slot_key[free_slot] = k;
        slot_data[free_slot] = v;
        slot_uses[free_slot] = 1;
        slot_age[free_slot] = 0;
        occupancy++;
      end
    end
  endtask

  // Valid is left high after acceptance so back-to-back items need one assignment per edge.
  task automatic send_item(input logic act, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] v);
    cache_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= k;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cache_predict(act, k, v, r);
    pending_results.push_back(r);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = cap;
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_result
    cache_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) begin
          report_mismatch($sformatf("hit: got %b expected %b", out_hit, want.hit));
        end
        if (out_read_value !== want.read_value) begin
          report_mismatch($sformatf("read_value: got %h expected %h",
                                    out_read_value, want.read_value));
        end
        if (out_evicted !== want.evicted) begin
          report_mismatch($sformatf("evicted: got %b expected %b",
                                    out_evicted, want.evicted));
        end
        if (out_evicted_key !== want.evicted_key) begin
          report_mismatch($sformatf("evicted_key: got %h expected %h",
                                    out_evicted_key, want.evicted_key));
        end
      end
    end
  end

  // Key and value extremes, overwrite of a present key, a miss on the empty store.
  task automatic test_extremes();
    send_item(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
    send_item(ACT_GET, 32'h0000_0000, 32'h0000_0000);
  endtask

  // Lowest count goes first; equal counts fall back to the least recent entry.
  task automatic test_eviction_order();
    wait_results_done();
    write_capacity(5'd2);
    send_item(ACT_PUT, 32'h0000_0100, 32'h1111_0100);
    send_item(ACT_PUT, 32'h0000_0200, 32'h1111_0200);
    send_item(ACT_GET, 32'h0000_0200, 32'h0);
    send_item(ACT_PUT, 32'h0000_0300, 32'h1111_0300);
    send_item(ACT_PUT, 32'h0000_0400, 32'h1111_0400);
    wait_results_done();
    write_capacity(5'd3);
    send_item(ACT_PUT, 32'h0000_0500, 32'h1111_0500);
    send_item(ACT_PUT, 32'h0000_0600, 32'h1111_0600);
  endtask

  // With storing disabled, puts change nothing but lookups still see old entries.
  task automatic test_capacity_zero();
    wait_results_done();
    write_capacity(5'd0);
    send_item(ACT_PUT, 32'h0000_0800, 32'h2222_0800);
    send_item(ACT_PUT, 32'h0000_0500, 32'h2222_0500);
    send_item(ACT_GET, 32'h0000_0800, 32'h0);
    send_item(ACT_GET, 32'h0000_0500, 32'h0);
  endtask

  // Capacity below the fill level: a new key swaps with one victim, nothing else drops.
  task automatic test_capacity_shrink();
    wait_results_done();
    write_capacity(5'd1);
    send_item(ACT_PUT, 32'h0000_0900, 32'h3333_0900);
    send_item(ACT_GET, 32'h0000_0900, 32'h0);
  endtask

  task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int n_items,
                                   input int pool_n, input bit idling);
    int i;
    int fresh;
    logic act;
    logic [KEY_W-1:0] k;
    wait_results_done();
    write_capacity(cap);
    idle_on = idling;
    fresh = $urandom_range(0, pool_n);
    for (i = 0; i < fresh; i++) begin
      key_pool[$urandom_range(0, pool_n - 1)] = $urandom;
    end
    for (i = 0; i < n_items; i++) begin
      act = $urandom_range(0, 1) ? ACT_PUT : ACT_GET;
      if ($urandom_range(0, 99) < 80) begin
        k = key_pool[$urandom_range(0, pool_n - 1)];
      end else begin
        k = $urandom;
      end
      send_item(act, k, $urandom);
    end
  endtask

  initial begin : main
    int i;
    for (i = 0; i < MAX_ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_data[i] = '0;
      slot_uses[i] = '0;
      slot_age[i] = 0;
    end
    for (i = 0; i < POOL_MAX; i++) begin
      key_pool[i] = $urandom;
    end
    occupancy = 0;
    cap_reg = 5'd16;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    test_extremes();
    test_eviction_order();
    test_capacity_zero();
    test_capacity_shrink();

    test_random_phase(5'd16, 150, 20, 1'b1);
    test_random_phase(5'd31, 120, 24, 1'b1);
    test_random_phase(5'd1, 100, 3, 1'b1);
    test_random_phase(5'd0, 60, 20, 1'b1);
    test_random_phase(5'd5, 120, 8, 1'b0);
    test_random_phase(5'd17, 100, 18, 1'b1);
    test_random_phase(CAP_W'($urandom_range(0, 31)), 150, $urandom_range(1, POOL_MAX), 1'b1);
    test_random_phase(5'd2, 80, 4, 1'b1);
    test_random_phase(5'd16, 120, 20, 1'b0);

    wait_results_done();
    repeat (MAX_ENTRIES + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
